[hdl/eptc_pkg.sv]
// eptc_pkg: shared types, calendar constants and reciprocal multipliers
// for the epoch-seconds-to-calendar pipeline; no dependencies
package eptc_pkg;

  // pipeline depth: two front stages, the rest run as parallel time and date lanes
  localparam int unsigned NUM_STAGES   = 9;
  localparam int unsigned FRONT_STAGES = 2;
  localparam int unsigned TAIL_STAGES  = NUM_STAGES - FRONT_STAGES;

  typedef logic [37:0] secs_t;   // clamped seconds, at most 253402300799
  typedef logic [21:0] days_t;   // whole days since the epoch

  localparam secs_t SECS_MAX = 38'd253402300799;

  localparam int unsigned SECS_PER_DAY  = 86400;
  localparam int unsigned SECS_PER_HOUR = 3600;
  localparam int unsigned SECS_PER_MIN  = 60;
  localparam int unsigned DAYS_PER_WEEK = 7;
  localparam int unsigned EPOCH_WDAY    = 4;       // day 0 is a thursday
  localparam int unsigned DAYS_TO_EPOCH = 719468;  // 0000-03-01 to 1970-01-01
  localparam int unsigned ERA_DAYS      = 146097;  // days in 400 years
  localparam int unsigned CENT_DAYS     = 36524;
  localparam int unsigned QUAD_DAYS     = 1460;
  localparam int unsigned YEAR_DAYS     = 365;
  localparam int unsigned ERA_YEARS     = 400;
  localparam int unsigned BASE_YEAR     = 1900;

  // floor(x / d) = (x * m) >> k with m = ceil(2^k / d), k = bits(x) + ceil(log2 d)
  localparam logic [31:0] RECIP_DAY  = 32'(((64'd1 << 41) + 64'd674) / 64'd675);
  localparam logic [22:0] RECIP_ERA  = 23'(((64'd1 << 40) + 64'd146096) / 64'd146097);
  localparam logic [22:0] RECIP_WEEK = 23'(((64'd1 << 25) + 64'd6) / 64'd7);
  localparam logic [18:0] RECIP_QUAD = 19'(((64'd1 << 29) + 64'd1459) / 64'd1460);
  localparam logic [18:0] RECIP_YEAR = 19'(((64'd1 << 27) + 64'd364) / 64'd365);
  localparam logic [17:0] RECIP_HOUR = 18'(((64'd1 << 29) + 64'd3599) / 64'd3600);
  localparam logic [12:0] RECIP_MIN  = 13'(((64'd1 << 18) + 64'd59) / 64'd60);
  localparam logic [11:0] RECIP_MON  = 12'(((64'd1 << 19) + 64'd152) / 64'd153);

  typedef struct packed {
    logic [5:0] second;
    logic [5:0] minute;
    logic [4:0] hour;
  } tod_t;

  typedef struct packed {
    logic [4:0]  mday;
    logic [3:0]  mon;
    logic [12:0] year;
    logic [2:0]  wday;
    logic [8:0]  yday;
  } date_t;

  // days before each month in a common year, january first
  function automatic logic [8:0] month_first_day(input logic [3:0] mon);
    logic [8:0] d;
    case (mon)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd59;
      4'd3:    d = 9'd90;
      4'd4:    d = 9'd120;
      4'd5:    d = 9'd151;
      4'd6:    d = 9'd181;
      4'd7:    d = 9'd212;
      4'd8:    d = 9'd243;
      4'd9:    d = 9'd273;
      4'd10:   d = 9'd304;
      4'd11:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

  // (153 * mp + 2) / 5: days from march 1st to the start of march-based month mp
  function automatic logic [8:0] march_month_offset(input logic [3:0] mp);
    logic [8:0] d;
    case (mp)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd61;
      4'd3:    d = 9'd92;
      4'd4:    d = 9'd122;
      4'd5:    d = 9'd153;
      4'd6:    d = 9'd184;
      4'd7:    d = 9'd214;
      4'd8:    d = 9'd245;
      4'd9:    d = 9'd275;
      4'd10:   d = 9'd306;
      4'd11:   d = 9'd337;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

[hdl/eptc_if.sv]
// eptc_if: valid/ready channel interfaces for the epoch-to-calendar block
// no dependencies
interface eptc_in_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] epoch_seconds;

  modport source (output valid, output epoch_seconds, input ready);
  modport sink   (input valid, input epoch_seconds, output ready);
endinterface

interface eptc_out_if;
  logic        valid;
  logic        ready;
  logic [5:0]  second_of_minute;
  logic [5:0]  minute_of_hour;
  logic [4:0]  hour_of_day;
  logic [4:0]  day_of_month;
  logic [3:0]  month_index;
  logic [12:0] years_since_1900;
  logic [2:0]  weekday;
  logic [8:0]  day_of_year;

  modport source (output valid, output second_of_minute, output minute_of_hour,
                  output hour_of_day, output day_of_month, output month_index,
                  output years_since_1900, output weekday, output day_of_year,
                  input ready);
  modport sink   (input valid, input second_of_minute, input minute_of_hour,
                  input hour_of_day, input day_of_month, input month_index,
                  input years_since_1900, input weekday, input day_of_year,
                  output ready);
endinterface

[hdl/eptc_pipe_ctrl.sv]
// eptc_pipe_ctrl: valid bits and per-stage load enables of the pipeline
// uses eptc_pkg
module eptc_pipe_ctrl (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [eptc_pkg::NUM_STAGES-1:0]  load_o
);
  import eptc_pkg::*;

  logic [NUM_STAGES-1:0] valid_q, valid_d;
  logic [NUM_STAGES-1:0] stage_ready;
  logic [NUM_STAGES-1:0] valid_in;

  // a stage takes a beat when it is empty or its content moves on
  always_comb begin
    stage_ready[NUM_STAGES-1] = !valid_q[NUM_STAGES-1] || out_ready_i;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      stage_ready[k] = !valid_q[k] || stage_ready[k+1];
    end
    valid_in[0] = in_valid_i;
    for (int k = 1; k < NUM_STAGES; k++) begin
      valid_in[k] = valid_q[k-1];
    end
    for (int k = 0; k < NUM_STAGES; k++) begin
      load_o[k]  = stage_ready[k] && valid_in[k];
      valid_d[k] = stage_ready[k] ? valid_in[k] : valid_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_ready_o  = stage_ready[0];
  assign out_valid_o = valid_q[NUM_STAGES-1];

endmodule

[hdl/eptc_front.sv]
// eptc_front: input clamp and split of seconds into whole days
// uses eptc_pkg
module eptc_front (
  input  logic                               clk_i,
  input  logic [eptc_pkg::FRONT_STAGES-1:0]  load_i,
  input  logic signed [63:0]                 epoch_i,
  output eptc_pkg::secs_t                    secs_o,
  output eptc_pkg::days_t                    days_o
);
  import eptc_pkg::*;

  secs_t       clamp_d, clamp_q;
  secs_t       secs_q;
  days_t       days_q;
  logic [62:0] day_prod;

  // negative counts go to zero, counts past year 9999 to its last second
  always_comb begin
    if (epoch_i[63]) begin
      clamp_d = '0;
    end else if (epoch_i[62:0] > 63'(SECS_MAX)) begin
      clamp_d = SECS_MAX;
    end else begin
      clamp_d = epoch_i[37:0];
    end
  end

  // 86400 = 128 * 675: shift out the power of two, then reciprocal of 675
  assign day_prod = 63'(clamp_q[37:7]) * 63'(RECIP_DAY);

  always_ff @(posedge clk_i) begin
    if (load_i[0]) begin
      clamp_q <= clamp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i[1]) begin
      secs_q <= clamp_q;
      days_q <= day_prod[62:41];
    end
  end

  assign secs_o = secs_q;
  assign days_o = days_q;

endmodule

[hdl/eptc_tod.sv]
// eptc_tod: time of day lane, seconds within the day to hour, minute, second
// uses eptc_pkg
module eptc_tod (
  input  logic                              clk_i,
  input  logic [eptc_pkg::TAIL_STAGES-1:0]  load_i,
  input  eptc_pkg::secs_t                   secs_i,
  input  eptc_pkg::days_t                   days_i,
  output eptc_pkg::tod_t                    tod_o
);
  import eptc_pkg::*;

  logic [16:0] rem_q, rem3_q;
  logic [4:0]  hour3_q, hour4_q, hour5_q;
  logic [11:0] part4_q, part5_q;
  logic [5:0]  min5_q;
  tod_t        tod6_q, tod7_q, tod8_q;

  logic [33:0] hour_prod;
  logic [23:0] min_prod;

  assign hour_prod = 34'(rem_q) * 34'(RECIP_HOUR);
  assign min_prod  = 24'(part4_q) * 24'(RECIP_MIN);

  always_ff @(posedge clk_i) begin
    if (load_i[0]) begin
      rem_q <= 17'(secs_i - 38'(days_i) * 38'(SECS_PER_DAY));
    end
    if (load_i[1]) begin
      rem3_q  <= rem_q;
      hour3_q <= hour_prod[33:29];
    end
    if (load_i[2]) begin
      part4_q <= 12'(rem3_q - 17'(hour3_q) * 17'(SECS_PER_HOUR));
      hour4_q <= hour3_q;
    end
    if (load_i[3]) begin
      part5_q <= part4_q;
      min5_q  <= min_prod[23:18];
      hour5_q <= hour4_q;
    end
    if (load_i[4]) begin
      tod6_q.second <= 6'(part5_q - 12'(min5_q) * 12'(SECS_PER_MIN));
      tod6_q.minute <= min5_q;
      tod6_q.hour   <= hour5_q;
    end
    if (load_i[5]) begin
      tod7_q <= tod6_q;
    end
    if (load_i[6]) begin
      tod8_q <= tod7_q;
    end
  end

  assign tod_o = tod8_q;

endmodule

[hdl/eptc_date.sv]
// eptc_date: date lane, whole days to gregorian date, weekday and day of year
// uses eptc_pkg
module eptc_date (
  input  logic                              clk_i,
  input  logic [eptc_pkg::TAIL_STAGES-1:0]  load_i,
  input  eptc_pkg::days_t                   days_i,
  output eptc_pkg::date_t                   date_o
);
  import eptc_pkg::*;

  // stage registers, numbered by pipeline stage
  logic [21:0] z2_q, wk2_q;
  logic [4:0]  era2_q, era3_q, era4_q, era5_q;
  logic [18:0] q7_2_q;
  logic [17:0] doe3_q, doe4_q, doe5_q;
  logic [2:0]  wday3_q, wday4_q, wday5_q, wday6_q, wday7_q;
  logic [17:0] t4_q;
  logic [8:0]  yoe5_q;
  logic [8:0]  doy6_q, doy7_q;
  logic [13:0] year6_q, year7_q;
  logic        leap6_q, leap7_q;
  logic [3:0]  mp7_q;
  date_t       date8_q;

  // stage 2: shift to a march-based calendar, era and week quotient
  logic [21:0] z_c, wk_c;
  logic [44:0] era_prod;
  logic [43:0] week_prod;

  assign z_c       = days_i + 22'(DAYS_TO_EPOCH);
  assign wk_c      = days_i + 22'(EPOCH_WDAY);
  assign era_prod  = 45'(z_c) * 45'(RECIP_ERA);
  assign week_prod = 44'(wk_c) * 44'(RECIP_WEEK);

  // stage 4: day of era with the leap days taken out
  logic [35:0] quad_prod;
  logic [2:0]  cent_cnt;
  logic        era_end;

  assign quad_prod = 36'(doe3_q) * 36'(RECIP_QUAD);
  assign cent_cnt  = 3'(doe3_q >= 18'(CENT_DAYS)) + 3'(doe3_q >= 18'(2 * CENT_DAYS))
                   + 3'(doe3_q >= 18'(3 * CENT_DAYS)) + 3'(doe3_q >= 18'(4 * CENT_DAYS));
  assign era_end   = (doe3_q == 18'(ERA_DAYS - 1));

  // stage 5: year of era
  logic [35:0] year_prod;

  assign year_prod = 36'(t4_q) * 36'(RECIP_YEAR);

  // stage 6: day of march-based year, full year and leap flag
  logic [1:0]  cent_of_era;
  logic [17:0] year_start;

  assign cent_of_era = 2'(yoe5_q >= 9'd100) + 2'(yoe5_q >= 9'd200) + 2'(yoe5_q >= 9'd300);
  assign year_start  = 18'(yoe5_q) * 18'(YEAR_DAYS) + 18'(yoe5_q[8:2]) - 18'(cent_of_era);

  // stage 7: march-based month
  logic [10:0] mon_num;
  logic [22:0] mon_prod;

  assign mon_num  = 11'(doy6_q) * 11'd5 + 11'd2;
  assign mon_prod = 23'(mon_num) * 23'(RECIP_MON);

  // stage 8: back to january-based month and year
  logic [3:0]  mon_c;
  logic [8:0]  dom0_c;
  logic        jan_feb;
  logic [8:0]  yday_c;
  logic [13:0] year_c;

  always_comb begin
    mon_c   = (mp7_q < 4'd10) ? mp7_q + 4'd2 : mp7_q - 4'd10;
    dom0_c  = doy7_q - march_month_offset(mp7_q);
    jan_feb = (mon_c < 4'd2);
    year_c  = year7_q + 14'(jan_feb) - 14'(BASE_YEAR);
    yday_c  = month_first_day(mon_c) + dom0_c + 9'(!jan_feb && leap7_q);
  end

  always_ff @(posedge clk_i) begin
    if (load_i[0]) begin
      z2_q   <= z_c;
      era2_q <= era_prod[44:40];
      wk2_q  <= wk_c;
      q7_2_q <= week_prod[43:25];
    end
    if (load_i[1]) begin
      doe3_q  <= 18'(z2_q - 22'(era2_q) * 22'(ERA_DAYS));
      era3_q  <= era2_q;
      wday3_q <= 3'(wk2_q - 22'(q7_2_q) * 22'(DAYS_PER_WEEK));
    end
    if (load_i[2]) begin
      t4_q    <= doe3_q - 18'(quad_prod[35:29]) + 18'(cent_cnt) - 18'(era_end);
      doe4_q  <= doe3_q;
      era4_q  <= era3_q;
      wday4_q <= wday3_q;
    end
    if (load_i[3]) begin
      yoe5_q  <= year_prod[35:27];
      doe5_q  <= doe4_q;
      era5_q  <= era4_q;
      wday5_q <= wday4_q;
    end
    if (load_i[4]) begin
      doy6_q  <= 9'(doe5_q - year_start);
      year6_q <= 14'(yoe5_q) + 14'(era5_q) * 14'(ERA_YEARS);
      // multiple of four and not a century, or a multiple of 400
      leap6_q <= (yoe5_q[1:0] == 2'd0) && (yoe5_q != 9'd100) && (yoe5_q != 9'd200)
                 && (yoe5_q != 9'd300);
      wday6_q <= wday5_q;
    end
    if (load_i[5]) begin
      mp7_q   <= mon_prod[22:19];
      doy7_q  <= doy6_q;
      year7_q <= year6_q;
      leap7_q <= leap6_q;
      wday7_q <= wday6_q;
    end
    if (load_i[6]) begin
      date8_q.mday <= 5'(dom0_c + 9'd1);
      date8_q.mon  <= mon_c;
      date8_q.year <= year_c[12:0];
      date8_q.wday <= wday7_q;
      date8_q.yday <= yday_c;
    end
  end

  assign date_o = date8_q;

endmodule

[hdl/epoch_seconds_to_calendar.sv]
// epoch_seconds_to_calendar: top level, signed epoch seconds to utc calendar fields
// uses eptc_pkg, eptc_if, eptc_pipe_ctrl, eptc_front, eptc_tod, eptc_date
//
//  channel  dir  handshake      payload
//  in_i     in   valid / ready  epoch_seconds (64 bit signed)
//  out_o    out  valid / ready  second, minute, hour, mday, month, year-1900,
//                               weekday, day of year
//
// nine register stages, one beat in per cycle while the output is not stalled
// the stage count follows the chain of reciprocal multiplies (days, era, four-year
// cycle, year of era, month, hour, minute), each followed by its own register
// reset clears only the stage valid bits; data registers load without reset
// a stalled output holds its beat while earlier stages keep filling bubbles;
// in_i.ready drops only once every stage holds a beat
module epoch_seconds_to_calendar (
  input  logic        clk_i,
  input  logic        rst_ni,
  eptc_in_if.sink     in_i,
  eptc_out_if.source  out_o
);
  import eptc_pkg::*;

  logic [NUM_STAGES-1:0] load;
  secs_t                 secs;
  days_t                 days;
  tod_t                  tod;
  date_t                 date;

  // valid bits and stage enables, stalls ripple back from out_o.ready
  eptc_pipe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .load_o      (load)
  );

  // stages 0 and 1: clamp, then whole days since the epoch
  eptc_front u_front (
    .clk_i   (clk_i),
    .load_i  (load[FRONT_STAGES-1:0]),
    .epoch_i (in_i.epoch_seconds),
    .secs_o  (secs),
    .days_o  (days)
  );

  // stages 2 to 8: seconds within the day to hour, minute, second
  eptc_tod u_tod (
    .clk_i  (clk_i),
    .load_i (load[NUM_STAGES-1:FRONT_STAGES]),
    .secs_i (secs),
    .days_i (days),
    .tod_o  (tod)
  );

  // stages 2 to 8: civil date from day count, weekday, day of year
  eptc_date u_date (
    .clk_i  (clk_i),
    .load_i (load[NUM_STAGES-1:FRONT_STAGES]),
    .days_i (days),
    .date_o (date)
  );

  // both lanes end in the last stage, which is the output register
  assign out_o.second_of_minute = tod.second;
  assign out_o.minute_of_hour   = tod.minute;
  assign out_o.hour_of_day      = tod.hour;
  assign out_o.day_of_month     = date.mday;
  assign out_o.month_index      = date.mon;
  assign out_o.years_since_1900 = date.year;
  assign out_o.weekday          = date.wday;
  assign out_o.day_of_year      = date.yday;

endmodule
